[rtl/tgb_pkg.sv]
// Shared types, constants and register codes for the triangle grid binner.
`timescale 1ns / 1ps

package tgb_pkg;

	// Fixed-point coordinate width (Q15.8) and the cell index layout (4 cells per axis max).
	localparam int COORD_W = 24;
	localparam int SECT_W = 2;
	localparam int CELL_W = 3 * SECT_W;

	// Grid parameter default and queue depth between front and back.
	localparam int GRID_SPLITS_DEF = 4;
	localparam int JOB_Q_DEPTH = 2;

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH = 2'd1;

	localparam logic signed [15:0] GRID_START_RST = -16'sd2000;
	localparam logic [15:0] CELL_WIDTH_RST = 16'd1000;

	localparam logic signed [COORD_W-1:0] Q_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic signed [COORD_W-1:0] Q_MAX = {1'b0, {(COORD_W-1){1'b1}}};

	typedef struct packed {
		logic signed [COORD_W-1:0] v0_x;
		logic signed [COORD_W-1:0] v0_y;
		logic signed [COORD_W-1:0] v0_z;
		logic signed [COORD_W-1:0] v1_x;
		logic signed [COORD_W-1:0] v1_y;
		logic signed [COORD_W-1:0] v1_z;
		logic signed [COORD_W-1:0] v2_x;
		logic signed [COORD_W-1:0] v2_y;
		logic signed [COORD_W-1:0] v2_z;
	} tri_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] a_x;
		logic signed [COORD_W-1:0] a_y;
		logic signed [COORD_W-1:0] a_z;
		logic signed [COORD_W-1:0] b_x;
		logic signed [COORD_W-1:0] b_y;
		logic signed [COORD_W-1:0] b_z;
		logic signed [COORD_W-1:0] c_x;
		logic signed [COORD_W-1:0] c_y;
		logic signed [COORD_W-1:0] c_z;
	} vert_set_t;

	typedef struct packed {
		logic [CELL_W-1:0] cell_res;
		vert_set_t verts;
		logic last;
	} cell_out_t;

	// One binned triangle: sector range per axis and the reordered vertices.
	typedef struct packed {
		logic [SECT_W-1:0] x0;
		logic [SECT_W-1:0] x1;
		logic [SECT_W-1:0] y0;
		logic [SECT_W-1:0] y1;
		logic [SECT_W-1:0] z0;
		logic [SECT_W-1:0] z1;
		vert_set_t verts;
	} bin_job_t;

endpackage

[rtl/tgb_front.sv]
// Front part: accepts a triangle, finds its bounding box and sector ranges.
`timescale 1ns / 1ps

module tgb_front import tgb_pkg::*; #(
	parameter int GRID_SPLITS = GRID_SPLITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  tri_in_t               tri_in,
	input  logic signed [15:0]    grid_start,
	input  logic [15:0]           cell_width,
	output logic                  job_push,
	input  logic                  job_full,
	output bin_job_t              job
);

	localparam int THR_W = 16 + SECT_W;

	logic accept;
	logic v_s1, v_s2, v_s3;
	tri_in_t tri_q;
	tri_in_t tri_neg;
	logic signed [COORD_W-1:0] crd [3][3];
	logic signed [COORD_W-1:0] mn_s2 [3];
	logic signed [COORD_W-1:0] mx_s2 [3];
	logic signed [COORD_W-1:0] pt [6];
	logic [15:0] whole_s3 [6];
	logic neg_s3 [6];
	logic [SECT_W-1:0] sect [6];
	logic [15:0] cwe;

	function automatic logic signed [COORD_W-1:0] neg_sat(input logic signed [COORD_W-1:0] v);
		return (v == Q_MIN) ? Q_MAX : -v;
	endfunction

	assign full = v_s1 | v_s2 | v_s3;
	assign accept = push & ~full;
	assign job_push = v_s3 & ~job_full;

	// Negate z on the way in so every axis is handled alike.
	always_comb begin
		tri_neg = tri_in;
		tri_neg.v0_z = neg_sat(tri_in.v0_z);
		tri_neg.v1_z = neg_sat(tri_in.v1_z);
		tri_neg.v2_z = neg_sat(tri_in.v2_z);
	end

	always_comb begin
		crd[0][0] = tri_q.v0_x;
		crd[0][1] = tri_q.v1_x;
		crd[0][2] = tri_q.v2_x;
		crd[1][0] = tri_q.v0_y;
		crd[1][1] = tri_q.v1_y;
		crd[1][2] = tri_q.v2_y;
		crd[2][0] = tri_q.v0_z;
		crd[2][1] = tri_q.v1_z;
		crd[2][2] = tri_q.v2_z;
		for (int a = 0; a < 3; a++) begin
			pt[2*a]   = mn_s2[a];
			pt[2*a+1] = mx_s2[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			if (v_s2) begin
				v_s3 <= 1'b1;
			end else if (job_push) begin
				v_s3 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tri_q <= tri_neg;
		end
		if (v_s1) begin
			for (int a = 0; a < 3; a++) begin
				if (crd[a][1] < crd[a][0] && crd[a][1] <= crd[a][2]) begin
					mn_s2[a] <= crd[a][1];
				end else if (crd[a][2] < crd[a][0] && crd[a][2] < crd[a][1]) begin
					mn_s2[a] <= crd[a][2];
				end else begin
					mn_s2[a] <= crd[a][0];
				end
				if (crd[a][1] > crd[a][0] && crd[a][1] >= crd[a][2]) begin
					mx_s2[a] <= crd[a][1];
				end else if (crd[a][2] > crd[a][0] && crd[a][2] > crd[a][1]) begin
					mx_s2[a] <= crd[a][2];
				end else begin
					mx_s2[a] <= crd[a][0];
				end
			end
		end
		if (v_s2) begin
			for (int k = 0; k < 6; k++) begin
				logic signed [COORD_W:0] off;
				off = {pt[k][COORD_W-1], pt[k]} -
					{grid_start[15], grid_start, 8'b0};
				neg_s3[k] <= off[COORD_W];
				whole_s3[k] <= off[COORD_W-1:8];
			end
		end
	end

	// Sector = number of cell boundaries at or below the whole part, capped by the grid.
	always_comb begin
		cwe = (cell_width == 16'd0) ? 16'd1 : cell_width;
		for (int k = 0; k < 6; k++) begin
			sect[k] = '0;
			for (int t = 1; t < GRID_SPLITS; t++) begin
				if (!neg_s3[k] && {{SECT_W{1'b0}}, whole_s3[k]} >=
						THR_W'(cwe) * THR_W'(t)) begin
					sect[k] = sect[k] + SECT_W'(1);
				end
			end
		end
	end

	always_comb begin
		job.x0 = sect[0];
		job.x1 = sect[1];
		job.y0 = sect[2];
		job.y1 = sect[3];
		job.z0 = sect[4];
		job.z1 = sect[5];
		job.verts.a_x = tri_q.v0_x;
		job.verts.a_y = tri_q.v0_y;
		job.verts.a_z = tri_q.v0_z;
		job.verts.b_x = tri_q.v2_x;
		job.verts.b_y = tri_q.v2_y;
		job.verts.b_z = tri_q.v2_z;
		job.verts.c_x = tri_q.v1_x;
		job.verts.c_y = tri_q.v1_y;
		job.verts.c_z = tri_q.v1_z;
	end

endmodule

[rtl/tgb_fifo.sv]
// Short job queue between the front and back parts.
`timescale 1ns / 1ps

module tgb_fifo import tgb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  bin_job_t wr_data,
	output logic     full,
	input  logic     rd,
	output bin_job_t rd_data,
	output logic     empty
);

	localparam int PTR_W = (JOB_Q_DEPTH > 1) ? $clog2(JOB_Q_DEPTH) : 1;

	bin_job_t mem [JOB_Q_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [PTR_W:0] cnt_q;

	assign full = (cnt_q == (PTR_W+1)'(JOB_Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign rd_data = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr && !full) begin
				wp_q <= (wp_q == PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : wp_q + PTR_W'(1);
			end
			if (rd && !empty) begin
				rp_q <= (rp_q == PTR_W'(JOB_Q_DEPTH - 1)) ? '0 : rp_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + (PTR_W+1)'(wr && !full) - (PTR_W+1)'(rd && !empty);
		end
	end

endmodule

[rtl/tgb_back.sv]
// Back part: walks the sector box of one job and emits one beat per cell.
`timescale 1ns / 1ps

module tgb_back import tgb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      job_empty,
	input  bin_job_t  job,
	output logic      job_pop,
	output logic      empty,
	input  logic      pop,
	output cell_out_t cell_out
);

	bin_job_t job_q;
	logic active_q;
	logic [SECT_W-1:0] x_q, y_q, z_q;
	cell_out_t out_q;
	logic out_valid_q;
	logic emit;
	logic last_cell;

	assign job_pop = ~active_q & ~job_empty;
	assign emit = active_q & (~out_valid_q | pop);
	assign last_cell = (x_q == job_q.x1) && (y_q == job_q.y1) && (z_q == job_q.z1);
	assign empty = ~out_valid_q;
	assign cell_out = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (job_pop) begin
				active_q <= 1'b1;
			end else if (emit && last_cell) begin
				active_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Advance z fastest, then y, then x.
	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q <= job;
			x_q <= job.x0;
			y_q <= job.y0;
			z_q <= job.z0;
		end else if (emit) begin
			if (z_q != job_q.z1) begin
				z_q <= z_q + SECT_W'(1);
			end else begin
				z_q <= job_q.z0;
				if (y_q != job_q.y1) begin
					y_q <= y_q + SECT_W'(1);
				end else begin
					y_q <= job_q.y0;
					x_q <= x_q + SECT_W'(1);
				end
			end
		end
		if (emit) begin
			out_q.cell_res <= {x_q, y_q, z_q};
			out_q.verts <= job_q.verts;
			out_q.last <= last_cell;
		end
	end

endmodule

[rtl/triangle_grid_binner_core.sv]
// Top level of the triangle grid binner: config registers, front, job queue and back.
// Flow: the front takes no new triangle until the last has passed bounding box, offset and
// sector compare and been handed to the job queue; the back loads each job, then emits one
// beat per cell while the receiver pops, cells being up to 64 per triangle.
// Reset: arst_n clears all control state at once and loads grid_start -2000, cell_width 1000.
`timescale 1ns / 1ps

module triangle_grid_binner_core import tgb_pkg::*; #(
	parameter int GRID_SPLITS = GRID_SPLITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Triangle input, queue style.
	input  logic                  push,
	output logic                  full,
	input  tri_in_t               tri_in,
	// Cell result output, queue style.
	output logic                  empty,
	input  logic                  pop,
	output cell_out_t             cell_out,
	// Configuration write port.
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic signed [15:0] grid_start_q;
	logic [15:0] cell_width_q;

	logic job_wr, job_full, job_empty, job_rd;
	bin_job_t job_wr_data, job_rd_data;

	// Register writes; drop writes to unknown indexes. A zero cell width
	// is treated as one inside the front part.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_start_q <= GRID_START_RST;
			cell_width_q <= CELL_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_GRID_START: grid_start_q <= cfg_data;
				REG_CELL_WIDTH: cell_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front: accept one triangle, negate z (saturating), find per-axis
	// min and max, subtract the grid start and turn the whole part into a
	// clamped sector range by comparing against multiples of the cell width.
	tgb_front #(
		.GRID_SPLITS(GRID_SPLITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.tri_in    (tri_in),
		.grid_start(grid_start_q),
		.cell_width(cell_width_q),
		.job_push  (job_wr),
		.job_full  (job_full),
		.job       (job_wr_data)
	);

	// Hold finished jobs so the front keeps binning while the back emits cells.
	tgb_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_wr),
		.wr_data(job_wr_data),
		.full   (job_full),
		.rd     (job_rd),
		.rd_data(job_rd_data),
		.empty  (job_empty)
	);

	// Back: walk x, then y, then z over the sector box, one beat per cell,
	// through an output register; a stalled beat holds the walk, and the next job waits in the queue.
	tgb_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_empty(job_empty),
		.job      (job_rd_data),
		.job_pop  (job_rd),
		.empty    (empty),
		.pop      (pop),
		.cell_out (cell_out)
	);

endmodule

[dv/triangle_grid_binner_core_tb.sv]
// Self-checking bench for the triangle grid binner: directed table, then random grid phases.
`timescale 1ns / 1ps

module triangle_grid_binner_core_tb import tgb_pkg::*; ();

	// One whole coordinate unit in Q15.8.
	localparam int WHOLE = 256;
	// Marks a table row whose cells come from the predictor instead of a hand-worked index.
	localparam int NO_HAND_CELL = -1;
	// Long receiver hold-off, in cycles, used once to back the block up into its input.
	localparam int HOLD_CYCLES = 400;
	// Quiet cycles before a register write, and after the last beat at the end.
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 40;
	// Cycles with no beat on either side before the run is declared hung.
	localparam int QUIET_LIMIT = 4000;
	localparam int N_DIR = 16;
	// Register indexes past the end of the map; writes there must leave the grid alone.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct {
		tri_in_t shape;
		int      cell_idx;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  push;
	logic                  full;
	tri_in_t               tri_in;
	logic                  empty;
	logic                  pop;
	cell_out_t             cell_out;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Our own copy of the grid registers, tracked as they are written.
	logic signed [15:0] grid_start_m = GRID_START_RST;
	logic [15:0]        cell_width_m = CELL_WIDTH_RST;

	// Cell beats still owed by the block, oldest first.
	cell_out_t cells_due [$];
	int        mismatches = 0;

	// Shared between the two sides: the one long hold-off, and stretches with no idling.
	bit hold_req = 1'b0;
	bit hold_taken = 1'b0;
	bit steady = 1'b0;

	string vert_names [9] = '{"a_x", "a_y", "a_z", "b_x", "b_y", "b_z", "c_x", "c_y", "c_z"};

	triangle_grid_binner_core #(
		.GRID_SPLITS(GRID_SPLITS_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.tri_in(tri_in),
		.empty(empty),
		.pop(pop),
		.cell_out(cell_out),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Append one beat to the owed list.
	function automatic void owe_beat(input cell_out_t beat);
		cells_due.insert(cells_due.size(), beat);
	endfunction

	// Idle length for either side: mostly none, some short, a few long.
	function automatic int pause_len();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Negate a coordinate; the most negative value has no positive twin, so clip it.
	function automatic logic signed [COORD_W-1:0] neg_clip(input logic signed [COORD_W-1:0] v);
		return (v == Q_MIN) ? Q_MAX : -v;
	endfunction

	function automatic int min3(input int a, input int b, input int c);
		int m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic int max3(input int a, input int b, input int c);
		int m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	// Sector of one coordinate under the current grid: whole units past the grid start,
	// divided by the cell width, clamped into the grid. A zero width behaves as one.
	function automatic logic [SECT_W-1:0] sector_for(input int coord);
		int offset;
		int pitch;
		int whole;
		offset = coord - int'(grid_start_m) * WHOLE;
		pitch = (cell_width_m == '0) ? 1 : int'(cell_width_m);
		if (offset < 0)
			return '0;
		whole = (offset >> 8) / pitch;
		if (whole > GRID_SPLITS_DEF - 1)
			whole = GRID_SPLITS_DEF - 1;
		return whole[SECT_W-1:0];
	endfunction

	// Vertices as they leave the block: order 0, 2, 1, each z negated.
	function automatic vert_set_t emitted_verts(input tri_in_t t);
		vert_set_t vs;
		vs.a_x = t.v0_x;
		vs.a_y = t.v0_y;
		vs.a_z = neg_clip(t.v0_z);
		vs.b_x = t.v2_x;
		vs.b_y = t.v2_y;
		vs.b_z = neg_clip(t.v2_z);
		vs.c_x = t.v1_x;
		vs.c_y = t.v1_y;
		vs.c_z = neg_clip(t.v1_z);
		return vs;
	endfunction

	// Work out every cell the triangle's bounding box touches and queue one beat for each,
	// x outermost, then y, then z, flagging the final one.
	function automatic void bin_triangle(input tri_in_t t);
		vert_set_t vs;
		cell_out_t beat;
		int lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;
		int total;
		int k;
		vs = emitted_verts(t);
		lo_x = int'(sector_for(min3(int'(t.v0_x), int'(t.v1_x), int'(t.v2_x))));
		hi_x = int'(sector_for(max3(int'(t.v0_x), int'(t.v1_x), int'(t.v2_x))));
		lo_y = int'(sector_for(min3(int'(t.v0_y), int'(t.v1_y), int'(t.v2_y))));
		hi_y = int'(sector_for(max3(int'(t.v0_y), int'(t.v1_y), int'(t.v2_y))));
		lo_z = int'(sector_for(min3(int'(vs.a_z), int'(vs.b_z), int'(vs.c_z))));
		hi_z = int'(sector_for(max3(int'(vs.a_z), int'(vs.b_z), int'(vs.c_z))));
		total = (hi_x - lo_x + 1) * (hi_y - lo_y + 1) * (hi_z - lo_z + 1);
		k = 0;
		for (int x = lo_x; x <= hi_x; x++)
			for (int y = lo_y; y <= hi_y; y++)
				for (int z = lo_z; z <= hi_z; z++) begin
					k++;
					beat.cell_res = CELL_W'(x * 16 + y * 4 + z);
					beat.verts = vs;
					beat.last = (k == total);
					owe_beat(beat);
				end
	endfunction

	function automatic tri_in_t triangle_at(input int ax, input int ay, input int az,
			input int bx, input int by, input int bz, input int cx, input int cy, input int cz);
		tri_in_t t;
		t.v0_x = COORD_W'(ax);
		t.v0_y = COORD_W'(ay);
		t.v0_z = COORD_W'(az);
		t.v1_x = COORD_W'(bx);
		t.v1_y = COORD_W'(by);
		t.v1_z = COORD_W'(bz);
		t.v2_x = COORD_W'(cx);
		t.v2_y = COORD_W'(cy);
		t.v2_z = COORD_W'(cz);
		return t;
	endfunction

	// Degenerate triangle: all three corners on one point, so exactly one cell.
	function automatic tri_in_t point_tri(input int x, input int y, input int z);
		return triangle_at(x, y, z, x, y, z, x, y, z);
	endfunction

	// Mostly small triangles around the live grid with random spread; one in five is raw
	// noise across the full field range so every bit toggles.
	function automatic tri_in_t random_shape();
		logic [223:0] noise;
		logic [8:0][COORD_W-1:0] f;
		longint pitch;
		longint centre [3];
		longint spread;
		longint v;
		int roll;
		if ($urandom_range(0, 4) == 0) begin
			noise = {$urandom(), $urandom(), $urandom(), $urandom(),
				$urandom(), $urandom(), $urandom()};
			return noise[215:0];
		end
		pitch = ((cell_width_m == '0) ? 64'sd1 : longint'(cell_width_m)) * WHOLE;
		for (int a = 0; a < 3; a++)
			centre[a] = longint'(grid_start_m) * WHOLE - pitch
				+ longint'($urandom_range(0, 32'(6 * pitch)));
		roll = $urandom_range(0, 9);
		spread = (roll < 5) ? pitch / 4 : (roll < 8) ? pitch : 3 * pitch;
		spread = longint'($urandom_range(0, 32'(spread)));
		for (int i = 0; i < 3; i++)
			for (int a = 0; a < 3; a++) begin
				v = centre[a] - spread + longint'($urandom_range(0, 32'(2 * spread)));
				if (v > longint'(Q_MAX))
					v = longint'(Q_MAX);
				if (v < -longint'(Q_MAX))
					v = -longint'(Q_MAX);
				// The grid sees z negated, so aim the negated value at it.
				f[8 - 3 * i - a] = COORD_W'((a == 2) ? -v : v);
			end
		return f;
	endfunction

	// Offer one triangle until it is taken, queue what it should produce, then idle for a random pause, possibly none.
	task automatic offer(input tri_in_t shape, input int hand_cell);
		cell_out_t beat;
		int gap;
		tri_in <= shape;
		push <= 1'b1;
		do
			@(posedge clk);
		while (full);
		if (hand_cell == NO_HAND_CELL)
			bin_triangle(shape);
		else begin
			beat.cell_res = CELL_W'(hand_cell);
			beat.verts = emitted_verts(shape);
			beat.last = 1'b1;
			owe_beat(beat);
		end
		gap = pause_len();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// One register write; the caller drops the enable after its last write.
	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		unique case (idx)
			REG_GRID_START: grid_start_m = val;
			REG_CELL_WIDTH: cell_width_m = val;
			default: ;
		endcase
	endtask

	// Reprogram the grid only once the block has drained: hold the input, wait for every
	// owed beat, let the pipeline settle, then write.
	task automatic program_grid(input logic signed [15:0] gs, input logic [15:0] cw,
			input bit poke_spare);
		push <= 1'b0;
		while (cells_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (poke_spare) begin
			reg_write(REG_SPARE_2, CFG_DATA_W'($urandom()));
			reg_write(REG_SPARE_3, CFG_DATA_W'($urandom()));
		end
		reg_write(REG_GRID_START, gs);
		reg_write(REG_CELL_WIDTH, cw);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input logic signed [15:0] gs, input logic [15:0] cw, input int count,
			input bit poke_spare, input bit squeeze);
		program_grid(gs, cw, poke_spare);
		for (int n = 0; n < count; n++) begin
			// Flip now and then into a stretch where neither side idles.
			if ($urandom_range(0, 15) == 0)
				steady = !steady;
			// Ask the receiver for its long hold-off while we keep offering.
			if (squeeze && n == 4)
				hold_req = 1'b1;
			offer(random_shape(), NO_HAND_CELL);
		end
	endtask

	initial begin : stimulus
		dir_row_t dir_rows [N_DIR];
		logic signed [15:0] gs_pick;
		logic [15:0] cw_pick;

		arst_n <= 1'b0;
		push <= 1'b0;
		tri_in <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= '0;
		cfg_data <= '0;

		// Directed rows under the reset grid: start -2000, width 1000, so sectors fall on
		// whole multiples of 1000 units from -2000. Hand-worked cells where they are obvious.
		dir_rows = '{
			// origin sits in sector 2 on every axis
			'{point_tri(0, 0, 0), 42},
			// most negative everywhere: x, y below the grid; z negation saturates, far beyond
			'{point_tri(int'(Q_MIN), int'(Q_MIN), int'(Q_MIN)), 3},
			// most positive everywhere: x, y beyond the grid; negated z below it
			'{point_tri(int'(Q_MAX), int'(Q_MAX), int'(Q_MAX)), 60},
			// exactly on the grid start
			'{point_tri(-2000 * WHOLE, -2000 * WHOLE, 2000 * WHOLE), 0},
			// one fraction below the grid start
			'{point_tri(-2000 * WHOLE - 1, -2000 * WHOLE - 1, 2000 * WHOLE + 1), 0},
			// last fraction of the first sector
			'{point_tri(-1001 * WHOLE + 255, -1001 * WHOLE + 255, 1001 * WHOLE - 255), 0},
			// first fraction of the second sector
			'{point_tri(-1000 * WHOLE, -1000 * WHOLE, 1000 * WHOLE), 21},
			// last fraction inside the grid
			'{point_tri(1999 * WHOLE + 255, 1999 * WHOLE + 255, -1999 * WHOLE - 255), 63},
			// first point past the grid, clamped to the top sector
			'{point_tri(2000 * WHOLE, 2000 * WHOLE, -2000 * WHOLE), 63},
			// distinct sector per axis, to pin the index weighting
			'{point_tri(-1000 * WHOLE, 0, -1500 * WHOLE), 27},
			// whole grid: all 64 cells
			'{triangle_at(int'(Q_MIN), int'(Q_MIN), int'(Q_MIN),
				int'(Q_MAX), int'(Q_MAX), int'(Q_MAX), 0, 0, 0), NO_HAND_CELL},
			// scattered corners, to check vertex order
			'{triangle_at(100 * WHOLE + 17, 200 * WHOLE, 300 * WHOLE,
				-700 * WHOLE, 900 * WHOLE + 3, -1200 * WHOLE,
				1500 * WHOLE + 7, -300 * WHOLE, 50 * WHOLE), NO_HAND_CELL},
			// span along x only
			'{triangle_at(-1500 * WHOLE, 0, 0, 1500 * WHOLE, 0, 0, 0, 0, 0), NO_HAND_CELL},
			// z extremes, saturation inside a range
			'{triangle_at(0, 0, int'(Q_MIN), 0, 0, int'(Q_MAX), 0, 0, 0), NO_HAND_CELL},
			// alternating bit patterns
			'{triangle_at(int'(24'sh5A5A5A), int'(24'sh5A5A5A), int'(24'sh5A5A5A),
				int'(24'shA5A5A5), int'(24'shA5A5A5), int'(24'shA5A5A5),
				int'(24'sh0F0F0F), int'(24'shF0F0F0), int'(24'sh0F0F0F)), NO_HAND_CELL},
			'{triangle_at(int'(24'sh7FFF00), int'(24'sh800100), int'(24'sh123456),
				int'(24'sh800100), int'(24'sh7FFF00), int'(24'shEDCBA9),
				int'(24'sh123456), int'(24'shEDCBA9), int'(24'sh7FFF00)), NO_HAND_CELL}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[r])
			offer(dir_rows[r].shape, dir_rows[r].cell_idx);

		// Reset grid again, after poking the unmapped indexes; the long hold-off lands here.
		run_phase(GRID_START_RST, CELL_WIDTH_RST, 50, 1'b1, 1'b1);
		// Extremes of both registers.
		run_phase(-16'sd32768, 16'd65535, 20, 1'b0, 1'b0);
		run_phase(16'sd32767, 16'd1, 15, 1'b1, 1'b0);
		// Zero cell width behaves as one unit.
		run_phase(16'sd0, 16'd0, 15, 1'b0, 1'b0);
		// Tight grid around the origin.
		run_phase(-16'sd64, 16'd32, 25, 1'b0, 1'b0);
		// Plausible random grid, then anything at all.
		gs_pick = 16'($urandom_range(0, 6000) - 3000);
		cw_pick = 16'($urandom_range(1, 2000));
		run_phase(gs_pick, cw_pick, 20, 1'b0, 1'b0);
		gs_pick = 16'($urandom());
		cw_pick = 16'($urandom());
		run_phase(gs_pick, cw_pick, 15, 1'b1, 1'b0);

		push <= 1'b0;
		while (cells_due.size() != 0)
			@(posedge clk);
		// Hold a little longer so any stray beat still shows up.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Receiver: after each beat pick a pause, and serve the one long hold-off on request.
	initial begin : drain_side
		int stall;
		stall = 0;
		pop <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				stall = pause_len();
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else
				pop <= 1'b1;
		end
	end

	// Compare one beat field by field against what we owe.
	task automatic check_beat(input cell_out_t want, input cell_out_t got);
		logic [8:0][COORD_W-1:0] wv;
		logic [8:0][COORD_W-1:0] gv;
		wv = want.verts;
		gv = got.verts;
		if (got.cell_res !== want.cell_res) begin
			$error("cell_res: expected %0d, got %0d", want.cell_res, got.cell_res);
			mismatches++;
		end
		for (int i = 0; i < 9; i++)
			if (gv[8 - i] !== wv[8 - i]) begin
				$error("%s: expected %0d, got %0d", vert_names[i],
					$signed(wv[8 - i]), $signed(gv[8 - i]));
				mismatches++;
			end
		if (got.last !== want.last) begin
			$error("last: expected %0d, got %0d", want.last, got.last);
			mismatches++;
		end
	endtask

	// Every popped beat must match the oldest owed one.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (cells_due.size() == 0) begin
				$error("cell beat with nothing owed: cell_res %0d", cell_out.cell_res);
				mismatches++;
			end else
				check_beat(cells_due.pop_front(), cell_out);
		end
	end

	// Hang detector: too long with no beat moving on either side ends the run.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (arst_n !== 1'b1 || (push && !full) || (pop && !empty))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

endmodule
